@@ design/nsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

	localparam int SLOT_IN_W = 7;
	localparam int SLOT_CODES = 2 ** SLOT_IN_W;
	localparam int BYTE_W = 32;
	localparam int CALL_W = 32;
	localparam int TIME_W = 48;

	typedef enum logic [1:0] {
		ACT_ENTER = 2'd0,
		ACT_EXIT  = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ENTER,
		S_EXIT_TICK,
		S_EXIT_CUR,
		S_EXIT_PAR,
		S_READ,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [CALL_W-1:0] calls;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] excl;
		logic [TIME_W-1:0] bytes;
	} slot_entry_t;

endpackage

`default_nettype wire

@@ design/nsp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read during write returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/nested_scope_profiler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Nested region profiler. Each word is enter, exit or read (action code 3 is ignored); each gives one result word.
// Counters per slot sit in one synchronous table memory with a single read port and a
// single write port, open frames in a second memory. One word is worked at a time. An exit
// steps through slot read, elapsed-tick subtract, slot write and parent read, parent write
// and result, two read-modify-write passes over the one table; an ignored enter or exit and
// action code 3 go straight to the result. A new word is taken while an earlier result
// still waits at the output. After reset the block runs a clearing pass over all NUM_SLOTS
// table entries before it takes its first word.
module nested_scope_profiler #(
	parameter int NUM_SLOTS   = 128,
	parameter int MAX_NESTING = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      action,
	input  wire logic [nsp_pkg::SLOT_IN_W-1:0]   slot,
	input  wire logic [nsp_pkg::BYTE_W-1:0]      byte_len,
	input  wire logic [nsp_pkg::TIME_W-1:0]      timestamp,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           status,
	output logic [nsp_pkg::CALL_W-1:0]           call_count,
	output logic [nsp_pkg::TIME_W-1:0]           inclusive_time,
	output logic [nsp_pkg::TIME_W-1:0]           exclusive_ticks,
	output logic [nsp_pkg::TIME_W-1:0]           bytes_done
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int FW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam int LW = $clog2(MAX_NESTING + 1);
	localparam int TW = nsp_pkg::TIME_W;
	localparam int FRM_W = SW + 2 * TW;
	localparam int ENT_W = $bits(nsp_pkg::slot_entry_t);

	typedef logic [SW-1:0] mod_tab_t [nsp_pkg::SLOT_CODES];

	function automatic mod_tab_t build_mod_tab();
		mod_tab_t t;
		int r;
		r = 0;
		for (int v = 0; v < nsp_pkg::SLOT_CODES; v++) begin
			t[v] = SW'(r);
			r = r + 1;
			if (r == NUM_SLOTS) begin
				r = 0;
			end
		end
		return t;
	endfunction

	localparam mod_tab_t MOD_TAB = build_mod_tab();

	nsp_pkg::state_t state_q, state_d;

	logic [SW-1:0]       clr_q;
	logic [SW-1:0]       active_q;
	logic [LW-1:0]       level_q;
	logic [LW-1:0]       lvl_m1;
	logic                full, empty, accept;

	logic [SW-1:0]       slot_q;
	logic [nsp_pkg::BYTE_W-1:0] bytes_q;
	logic [TW-1:0]       ts_q;
	logic [TW-1:0]       ticks_q;
	logic [TW-1:0]       prior_q;
	logic [SW-1:0]       par_q;
	nsp_pkg::slot_entry_t cur_ent_q, cur_new, cur_new_q, par_src;

	logic [1:0]          res_status_q;
	nsp_pkg::slot_entry_t res_ent_q;
	logic                out_valid_q;

	logic                tbl_we, tbl_re;
	logic [SW-1:0]       tbl_waddr, tbl_raddr;
	nsp_pkg::slot_entry_t tbl_wdata, tbl_rdata;
	logic [ENT_W-1:0]    tbl_rbits;

	logic                frm_we, frm_re;
	logic [FW-1:0]       frm_waddr, frm_raddr;
	logic [FRM_W-1:0]    frm_wdata, frm_rdata;
	logic [SW-1:0]       frm_parent;
	logic [TW-1:0]       frm_prior, frm_start;

	assign full   = (level_q == LW'(MAX_NESTING));
	assign empty  = (level_q == '0);
	assign lvl_m1 = level_q - LW'(1);
	assign in_ready = (state_q == nsp_pkg::S_IDLE);
	assign accept = in_valid && in_ready;

	assign tbl_rdata = nsp_pkg::slot_entry_t'(tbl_rbits);
	assign frm_parent = frm_rdata[FRM_W-1 -: SW];
	assign frm_prior  = frm_rdata[2*TW-1 -: TW];
	assign frm_start  = frm_rdata[TW-1:0];

	always_comb begin
		cur_new       = cur_ent_q;
		cur_new.calls = cur_ent_q.calls + nsp_pkg::CALL_W'(1);
		cur_new.excl  = cur_ent_q.excl + ticks_q;
		cur_new.total = prior_q + ticks_q;
	end

	// parent read was issued while the slot itself was written: forward it
	assign par_src = (par_q == active_q) ? cur_new_q : tbl_rdata;

	always_comb begin
		state_d = state_q;
		case (state_q)
			nsp_pkg::S_CLEAR: begin
				if (clr_q == SW'(NUM_SLOTS - 1)) begin
					state_d = nsp_pkg::S_IDLE;
				end
			end
			nsp_pkg::S_IDLE: begin
				if (accept) begin
					case (action)
						nsp_pkg::ACT_ENTER: state_d = full ? nsp_pkg::S_FIN : nsp_pkg::S_ENTER;
						nsp_pkg::ACT_EXIT:  state_d = empty ? nsp_pkg::S_FIN : nsp_pkg::S_EXIT_TICK;
						nsp_pkg::ACT_READ:  state_d = nsp_pkg::S_READ;
						default:            state_d = nsp_pkg::S_FIN;
					endcase
				end
			end
			nsp_pkg::S_ENTER:     state_d = nsp_pkg::S_FIN;
			nsp_pkg::S_EXIT_TICK: state_d = nsp_pkg::S_EXIT_CUR;
			nsp_pkg::S_EXIT_CUR:  state_d = nsp_pkg::S_EXIT_PAR;
			nsp_pkg::S_EXIT_PAR:  state_d = nsp_pkg::S_FIN;
			nsp_pkg::S_READ:      state_d = nsp_pkg::S_FIN;
			nsp_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = nsp_pkg::S_IDLE;
				end
			end
			default: state_d = nsp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = active_q;
		tbl_wdata = '0;
		tbl_re    = 1'b0;
		tbl_raddr = active_q;
		frm_we    = 1'b0;
		frm_waddr = level_q[FW-1:0];
		frm_wdata = {active_q, tbl_rdata.total, ts_q};
		frm_re    = 1'b0;
		frm_raddr = lvl_m1[FW-1:0];
		case (state_q)
			nsp_pkg::S_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
			end
			nsp_pkg::S_IDLE: begin
				if (accept) begin
					tbl_re    = 1'b1;
					tbl_raddr = (action == nsp_pkg::ACT_EXIT) ? active_q : MOD_TAB[slot];
					frm_re    = 1'b1;
				end
			end
			nsp_pkg::S_ENTER: begin
				tbl_we          = 1'b1;
				tbl_waddr       = slot_q;
				tbl_wdata       = tbl_rdata;
				tbl_wdata.bytes = tbl_rdata.bytes + TW'(bytes_q);
				frm_we          = 1'b1;
			end
			nsp_pkg::S_EXIT_CUR: begin
				tbl_we    = 1'b1;
				tbl_waddr = active_q;
				tbl_wdata = cur_new;
				tbl_re    = 1'b1;
				tbl_raddr = par_q;
			end
			nsp_pkg::S_EXIT_PAR: begin
				tbl_we         = 1'b1;
				tbl_waddr      = par_q;
				tbl_wdata      = par_src;
				tbl_wdata.excl = par_src.excl - ticks_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsp_pkg::S_CLEAR;
			clr_q       <= '0;
			active_q    <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nsp_pkg::S_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (state_q == nsp_pkg::S_ENTER) begin
				active_q <= slot_q;
				level_q  <= level_q + LW'(1);
			end
			if (state_q == nsp_pkg::S_EXIT_PAR) begin
				active_q <= par_q;
				level_q  <= lvl_m1;
			end
			if (state_q == nsp_pkg::S_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q  <= MOD_TAB[slot];
			bytes_q <= byte_len;
			ts_q    <= timestamp;
			res_ent_q <= '0;
			if (action == nsp_pkg::ACT_ENTER && full) begin
				res_status_q <= nsp_pkg::ST_FULL;
			end else if (action == nsp_pkg::ACT_EXIT && empty) begin
				res_status_q <= nsp_pkg::ST_EMPTY;
			end else begin
				res_status_q <= nsp_pkg::ST_OK;
			end
		end
		if (state_q == nsp_pkg::S_EXIT_TICK) begin
			ticks_q   <= ts_q - frm_start;
			prior_q   <= frm_prior;
			par_q     <= frm_parent;
			cur_ent_q <= tbl_rdata;
		end
		if (state_q == nsp_pkg::S_EXIT_CUR) begin
			cur_new_q <= cur_new;
		end
		if (state_q == nsp_pkg::S_READ) begin
			res_ent_q <= tbl_rdata;
		end
		if (state_q == nsp_pkg::S_FIN && (!out_valid_q || out_ready)) begin
			status          <= res_status_q;
			call_count      <= res_ent_q.calls;
			inclusive_time  <= res_ent_q.total;
			exclusive_ticks <= res_ent_q.excl;
			bytes_done      <= res_ent_q.bytes;
		end
	end

	assign out_valid = out_valid_q;

	nsp_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rbits)
	);

	nsp_ram #(
		.WIDTH (FRM_W),
		.DEPTH (MAX_NESTING)
	) u_frame_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.re    (frm_re),
		.raddr (frm_raddr),
		.rdata (frm_rdata)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(MAX_NESTING))
		else $error("stack level beyond nesting depth");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == nsp_pkg::S_FIN))
		else $error("result word raised outside the finish step");

	a_exit_pops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nsp_pkg::S_EXIT_PAR |=> level_q == $past(lvl_m1))
		else $error("exit did not pop one frame");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nsp_pkg::S_IDLE |-> !tbl_we && !frm_we)
		else $error("memory written while idle");

endmodule

`default_nettype wire
